FILE: sv/assert_macros.svh
// assertion macros for the rtl file that carries checks
// expects clk and rst_n (active low) in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent matched
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/jdc_pkg.sv
// shared widths, constants and stage word types of the julian day converter
// no dependencies; every other rtl file refers to it by scoped names
package jdc_pkg;

    // field widths
    localparam int FRAC_BITS = 32;
    localparam int WHOLE_W   = 24;
    localparam int YEAR_W    = 16;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;

    // stream word widths, whole bytes
    localparam int IN_DATA_W  = ((WHOLE_W + FRAC_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((YEAR_W + MONTH_W + DAY_W + FRAC_BITS + 7) / 8) * 8;

    // day number after the half day carry and the gregorian shift
    localparam int JD_W = WHOLE_W + 1;

    // calendar constants
    localparam int GREG_START    = 2299160;
    localparam int NEG_FIX_LIMIT = -1401;
    localparam int A_OFFSET      = 7468865;   // 4 * 1867216.25
    localparam int B_OFFSET      = 1524;
    localparam int C_OFFSET      = 2442;      // 20 * 122.1
    localparam int MUL_D         = 1461;      // 4 * 365.25
    localparam int MONTH_SPLIT   = 14;
    localparam int MONTH_LOW_OFS = 1;
    localparam int MONTH_HIGH_OFS = 13;
    localparam int FEB           = 2;
    localparam int YEAR_OFS_HI   = 4716;
    localparam int YEAR_OFS_LO   = 4715;

    // exact division by reciprocal: n < 2^N, S = N + ceil(log2 D), M = ceil(2^S / D)
    localparam longint unsigned D_A = 146097;
    localparam longint unsigned D_C = 7305;
    localparam longint unsigned D_E = 306001;
    localparam longint unsigned D_T = 10000;

    // gregorian century count, numerator 4*jd - 7468865 below 2^25
    localparam int NA_W = JD_W;
    localparam int S_A  = NA_W + 18;
    localparam int MA_W = NA_W + 1;
    localparam longint unsigned M_A = ((64'd1 << S_A) + D_A - 64'd1) / D_A;
    localparam int A_W  = NA_W + MA_W - S_A;

    // year count, magnitude of 20*b - 2442
    localparam int NUM_W = JD_W + 5;
    localparam int MAG_W = NUM_W - 1;
    localparam int S_C   = MAG_W + 13;
    localparam int MC_W  = MAG_W + 1;
    localparam longint unsigned M_C = ((64'd1 << S_C) + D_C - 64'd1) / D_C;
    localparam int QC_W  = MAG_W + MC_W - S_C;
    localparam int C_W   = QC_W + 1;

    // 1461 * c before the floor shift
    localparam int P_W = C_W + 11;

    // month count: e = floor(10000*x / 306001), the 10000 folded into the constant
    localparam int X_W  = 10;
    localparam int NE_W = 24;
    localparam int S_E  = NE_W + 19;
    localparam longint unsigned M_E = ((64'd1 << S_E) + D_E - 64'd1) / D_E;
    localparam int KE_W = 39;
    localparam longint unsigned K_E = D_T * M_E;
    localparam int E_W  = X_W + KE_W - S_E;

    // days before the month: floor(306001*e / 10000), the 306001 folded in
    localparam int NT_W = 25;
    localparam int S_T  = NT_W + 14;
    localparam longint unsigned M_T = ((64'd1 << S_T) + D_T - 64'd1) / D_T;
    localparam int KT_W = 44;
    localparam longint unsigned K_T = D_E * M_T;
    localparam int T_W  = E_W + KT_W - S_T;
    localparam int DAYC_W = T_W + 1;

    // pipeline stage words
    typedef struct packed {
        logic [JD_W-1:0]      jd;
        logic [FRAC_BITS-1:0] dayf;
    } s1_t;

    typedef struct packed {
        logic [JD_W-1:0]      jd;
        logic                 greg;
        logic [A_W-1:0]       a;
        logic [FRAC_BITS-1:0] dayf;
    } s2_t;

    typedef struct packed {
        logic [JD_W-1:0]      b;
        logic [MAG_W-1:0]     mag;
        logic                 neg;
        logic                 fix;
        logic [FRAC_BITS-1:0] dayf;
    } s3_t;

    typedef struct packed {
        logic [JD_W-1:0]      b;
        logic [QC_W-1:0]      qc;
        logic                 neg;
        logic                 fix;
        logic [FRAC_BITS-1:0] dayf;
    } s4_t;

    typedef struct packed {
        logic [C_W-1:0]       c;
        logic [X_W-1:0]       x;
        logic [FRAC_BITS-1:0] dayf;
    } s5_t;

    typedef struct packed {
        logic [C_W-1:0]       c;
        logic [X_W-1:0]       x;
        logic [E_W-1:0]       e;
        logic [FRAC_BITS-1:0] dayf;
    } s6_t;

    typedef struct packed {
        logic [FRAC_BITS-1:0] dayf;
        logic [DAY_W-1:0]     day;
        logic [MONTH_W-1:0]   month;
        logic [YEAR_W-1:0]    year;
    } date_t;

endpackage

FILE: sv/jdc_norm.sv
// stages one to three: half day carry, gregorian correction, year count numerator
// depends on jdc_pkg
module jdc_norm (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [jdc_pkg::WHOLE_W-1:0]  jd_whole,
    input  logic [jdc_pkg::FRAC_BITS:0]  jd_frac,
    output logic                     out_valid,
    input  logic                     out_ready,
    output jdc_pkg::s3_t             out_data
);

    localparam int FB   = jdc_pkg::FRAC_BITS;
    localparam int JW   = jdc_pkg::JD_W;
    localparam int PA_W = jdc_pkg::NA_W + jdc_pkg::MA_W;
    localparam int NW   = jdc_pkg::NUM_W;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    jdc_pkg::s1_t s1_next, s1_reg;
    jdc_pkg::s2_t s2_next, s2_reg;
    jdc_pkg::s3_t s3_next, s3_reg;

    logic [FB+1:0]            fsum;
    logic [JW-1:0]            jd_ext;
    logic [JW+1:0]            na_full;
    logic [jdc_pkg::NA_W-1:0] na;
    logic [PA_W-1:0]          prod_a;
    logic [jdc_pkg::A_W-1:0]  corr;
    logic [JW-1:0]            jd2;
    logic [JW-1:0]            b;
    logic [NW-1:0]            bx;
    logic [NW-1:0]            num;
    logic [NW-1:0]            magf;

    // stall chain: a stage loads when empty or when its successor moves
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: add half a day, carry or borrow one day
    assign fsum   = {jd_frac[FB], jd_frac} + {2'b00, 1'b1, {(FB-1){1'b0}}};
    assign jd_ext = {jd_whole[jdc_pkg::WHOLE_W-1], jd_whole};

    always_comb
    begin
        s1_next.dayf = fsum[FB-1:0];
        if (fsum[FB+1])
        begin
            s1_next.jd = jd_ext - JW'(1);
        end
        else if (fsum[FB])
        begin
            s1_next.jd = jd_ext + JW'(1);
        end
        else
        begin
            s1_next.jd = jd_ext;
        end
    end

    // stage 2: century count a = (4*jd - 7468865) / 146097 by reciprocal
    assign na_full = {s1_reg.jd, 2'b00} - (JW+2)'(jdc_pkg::A_OFFSET);
    assign na      = na_full[jdc_pkg::NA_W-1:0];
    assign prod_a  = PA_W'(na) * PA_W'(jdc_pkg::M_A[jdc_pkg::MA_W-1:0]);

    always_comb
    begin
        s2_next.jd   = s1_reg.jd;
        s2_next.greg = $signed(s1_reg.jd) > $signed(JW'(jdc_pkg::GREG_START));
        s2_next.a    = prod_a[jdc_pkg::S_A +: jdc_pkg::A_W];
        s2_next.dayf = s1_reg.dayf;
    end

    // stage 3: gregorian shift, b, and sign and magnitude of 20*b - 2442
    assign corr = jdc_pkg::A_W'(1) + s2_reg.a - (s2_reg.a >> 2);
    assign jd2  = s2_reg.jd + (s2_reg.greg ? JW'(corr) : JW'(0));
    assign b    = jd2 + JW'(jdc_pkg::B_OFFSET);
    assign bx   = {{(NW-JW){b[JW-1]}}, b};
    assign num  = (bx << 4) + (bx << 2) - NW'(jdc_pkg::C_OFFSET);
    assign magf = num[NW-1] ? (~num + NW'(1)) : num;

    always_comb
    begin
        s3_next.b    = b;
        s3_next.mag  = magf[jdc_pkg::MAG_W-1:0];
        s3_next.neg  = num[NW-1];
        s3_next.fix  = $signed(jd2) < $signed(JW'(jdc_pkg::NEG_FIX_LIMIT));
        s3_next.dayf = s2_reg.dayf;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule

FILE: sv/jdc_year.sv
// stages four and five: year count c, its floor times 365.25, day of year x
// depends on jdc_pkg
module jdc_year (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  jdc_pkg::s3_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output jdc_pkg::s5_t out_data
);

    localparam int PC_W = jdc_pkg::MAG_W + jdc_pkg::MC_W;
    localparam int CW   = jdc_pkg::C_W;
    localparam int PW   = jdc_pkg::P_W;
    localparam int JW   = jdc_pkg::JD_W;

    logic v4_reg, v5_reg;
    logic rdy4, rdy5;
    jdc_pkg::s4_t s4_next, s4_reg;
    jdc_pkg::s5_t s5_next, s5_reg;

    logic [PC_W-1:0] prod_c;
    logic [CW-1:0]   cq;
    logic [CW-1:0]   cs;
    logic [CW-1:0]   c;
    logic [PW-1:0]   cx;
    logic [PW-1:0]   p;
    logic [PW-1:0]   dq;
    logic [PW-1:0]   bx;
    logic [PW-1:0]   xf;

    // stall chain
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign in_ready = rdy4;

    // stage 4: |20*b - 2442| / 7305 by reciprocal
    assign prod_c = PC_W'(in_data.mag) * PC_W'(jdc_pkg::M_C[jdc_pkg::MC_W-1:0]);

    always_comb
    begin
        s4_next.b    = in_data.b;
        s4_next.qc   = prod_c[jdc_pkg::S_C +: jdc_pkg::QC_W];
        s4_next.neg  = in_data.neg;
        s4_next.fix  = in_data.fix;
        s4_next.dayf = in_data.dayf;
    end

    // stage 5: signed quotient toward zero, negative date fix, x = b - floor(1461*c/4)
    assign cq = {1'b0, s4_reg.qc};
    assign cs = s4_reg.neg ? (~cq + CW'(1)) : cq;
    assign c  = cs - (s4_reg.fix ? CW'(1) : CW'(0));
    assign cx = {{(PW-CW){c[CW-1]}}, c};
    assign p  = cx * PW'(jdc_pkg::MUL_D);
    assign dq = {{2{p[PW-1]}}, p[PW-1:2]};
    assign bx = {{(PW-JW){s4_reg.b[JW-1]}}, s4_reg.b};
    assign xf = bx - dq;

    always_comb
    begin
        s5_next.c    = c;
        s5_next.x    = xf[jdc_pkg::X_W-1:0];
        s5_next.dayf = s4_reg.dayf;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= in_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy4 && in_valid)
        begin
            s4_reg <= s4_next;
        end
        if (rdy5 && v4_reg)
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

endmodule

FILE: sv/jdc_date.sv
// stages six and seven: month count e, then day, month and year into the output register
// depends on jdc_pkg
module jdc_date (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  jdc_pkg::s5_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output jdc_pkg::date_t out_data
);

    localparam int PE_W = jdc_pkg::X_W + jdc_pkg::KE_W;
    localparam int PT_W = jdc_pkg::E_W + jdc_pkg::KT_W;
    localparam int EW   = jdc_pkg::E_W;
    localparam int DW   = jdc_pkg::DAYC_W;
    localparam int YW   = jdc_pkg::YEAR_W;

    logic v6_reg, v7_reg;
    logic rdy6, rdy7;
    jdc_pkg::s6_t   s6_next, s6_reg;
    jdc_pkg::date_t s7_next, s7_reg;

    logic [PE_W-1:0]           prod_e;
    logic [PT_W-1:0]           prod_t;
    logic [jdc_pkg::T_W-1:0]   t;
    logic [DW-1:0]             dayc;
    logic [EW-1:0]             month_full;
    logic [YW-1:0]             year;

    // stall chain, stage 7 is the output register
    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign in_ready = rdy6;

    // stage 6: e = floor(10000*x / 306001)
    assign prod_e = PE_W'(in_data.x) * PE_W'(jdc_pkg::K_E[jdc_pkg::KE_W-1:0]);

    always_comb
    begin
        s6_next.c    = in_data.c;
        s6_next.x    = in_data.x;
        s6_next.e    = prod_e[jdc_pkg::S_E +: EW];
        s6_next.dayf = in_data.dayf;
    end

    // stage 7: day = x - floor(30.6001*e), month from e, year from c and month
    assign prod_t = PT_W'(s6_reg.e) * PT_W'(jdc_pkg::K_T[jdc_pkg::KT_W-1:0]);
    assign t      = prod_t[jdc_pkg::S_T +: jdc_pkg::T_W];
    assign dayc   = {{(DW-jdc_pkg::X_W){1'b0}}, s6_reg.x} - {{(DW-jdc_pkg::T_W){1'b0}}, t};

    assign month_full = s6_reg.e - ((s6_reg.e < EW'(jdc_pkg::MONTH_SPLIT)) ?
                        EW'(jdc_pkg::MONTH_LOW_OFS) : EW'(jdc_pkg::MONTH_HIGH_OFS));
    assign year       = s6_reg.c[YW-1:0] - ((month_full > EW'(jdc_pkg::FEB)) ?
                        YW'(jdc_pkg::YEAR_OFS_HI) : YW'(jdc_pkg::YEAR_OFS_LO));

    always_comb
    begin
        s7_next.dayf  = s6_reg.dayf;
        s7_next.day   = dayc[jdc_pkg::DAY_W-1:0];
        s7_next.month = month_full[jdc_pkg::MONTH_W-1:0];
        s7_next.year  = year;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy6)
            begin
                v6_reg <= in_valid;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (rdy6 && in_valid)
        begin
            s6_reg <= s6_next;
        end
        if (rdy7 && v6_reg)
        begin
            s7_reg <= s7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_data  = s7_reg;

endmodule

FILE: sv/julian_day_to_calendar.sv
// julian date to calendar date: seven register stages, uses jdc_pkg, jdc_norm, jdc_year, jdc_date
// path: an accepted word passes the stage registers s1 to s7 in order; m_tvalid rises when s7 loads
// throughput: one word per cycle while m_tready stays high; each stage loads when empty or when the next one moves,
// so gaps are squeezed out and s_tready falls only when all seven stages hold a word
// reset: rst_n asynchronous, active low, empties every stage; no data registers are cleared
`include "assert_macros.svh"

module julian_day_to_calendar (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // jd_whole [23:0], jd_frac [56:24], zero pad above
    input  logic [jdc_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // cal_year [15:0], cal_month [19:16], cal_day [24:20], day_frac [56:25], zero pad above
    output logic [jdc_pkg::OUT_DATA_W-1:0]     m_tdata
);

    logic [jdc_pkg::WHOLE_W-1:0] jd_whole;
    logic [jdc_pkg::FRAC_BITS:0] jd_frac;
    logic                        v3, r3, v5, r5;
    jdc_pkg::s3_t                d3;
    jdc_pkg::s5_t                d5;
    jdc_pkg::date_t              date;

    // unpack the input word
    assign jd_whole = s_tdata[jdc_pkg::WHOLE_W-1:0];
    assign jd_frac  = s_tdata[jdc_pkg::WHOLE_W +: jdc_pkg::FRAC_BITS+1];

    jdc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .jd_whole  (jd_whole),
        .jd_frac   (jd_frac),
        .out_valid (v3),
        .out_ready (r3),
        .out_data  (d3)
    );

    jdc_year u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_data   (d3),
        .out_valid (v5),
        .out_ready (r5),
        .out_data  (d5)
    );

    jdc_date u_date (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5),
        .in_ready  (r5),
        .in_data   (d5),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (date)
    );

    // pack the output word
    assign m_tdata = jdc_pkg::OUT_DATA_W'({date.dayf, date.day, date.month, date.year});

    // input side backs up only when the whole pipe is full and the output is stalled
    `ASSERT_CLK(a_full_stall, !s_tready |-> (m_tvalid && !m_tready), "input stalled with room in the pipe")

    // an accepted word is not lost in the pipe while the output keeps taking
    `ASSERT_NEXT(a_latency, s_tvalid && s_tready ##1 m_tready [*6], m_tvalid, "word lost in the pipe")

endmodule

FILE: test/tb_julian_day_to_calendar.sv
// testbench for julian_day_to_calendar: directed and random julian dates, stream stalls
// on both sides, every output word checked against a calendar predictor in a scoreboard
// depends on jdc_pkg and the julian_day_to_calendar rtl
`timescale 1ns / 100ps

module tb_julian_day_to_calendar;

    localparam int IN_PAD      = jdc_pkg::IN_DATA_W - (jdc_pkg::WHOLE_W + jdc_pkg::FRAC_BITS + 1);
    localparam int DATE_W      = $bits(jdc_pkg::date_t);
    localparam int HOLD_CYCLES = 40;
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_WORDS = 1100;
    localparam int CALM_TAIL   = 150;

    // expected calendar dates, predicted from accepted julian dates
    class date_scoreboard;
        jdc_pkg::date_t pending[$];
        int errors;

        localparam longint ONE_DAY  = longint'(1) << jdc_pkg::FRAC_BITS;
        localparam longint HALF_DAY = longint'(1) << (jdc_pkg::FRAC_BITS - 1);
        localparam longint DIV_A    = 146097;
        localparam longint DIV_C    = 7305;
        localparam longint DIV_E    = 306001;
        localparam longint SCALE_E  = 10000;

        // calendar date of one julian date, exact integer steps
        function jdc_pkg::date_t julian_to_date(logic [23:0] whole, logic [32:0] frac);
            longint jd, fr, dayf, a, b, c, num, d, e, day, month, year;
            jdc_pkg::date_t r;
            jd = $signed(whole);
            fr = $signed(frac);

            // shift to midnight and renormalize the fraction
            dayf = fr + HALF_DAY;
            if (dayf >= ONE_DAY)
            begin
                dayf = dayf - ONE_DAY;
                jd = jd + 1;
            end
            else if (dayf < 0)
            begin
                dayf = dayf + ONE_DAY;
                jd = jd - 1;
            end

            // gregorian correction
            if (jd > jdc_pkg::GREG_START)
            begin
                a = (4 * jd - jdc_pkg::A_OFFSET) / DIV_A;
                jd = jd + 1 + a - a / 4;
            end

            // year count, with the fix for very negative days
            b = jd + jdc_pkg::B_OFFSET;
            c = (20 * b - jdc_pkg::C_OFFSET) / DIV_C;
            if (jd < jdc_pkg::NEG_FIX_LIMIT)
                c = c - 1;

            // days in whole years, rounded down
            num = jdc_pkg::MUL_D * c;
            d = num / 4;
            if ((num % 4) != 0 && num < 0)
                d = d - 1;

            // month count and day of month
            e = (SCALE_E * (b - d)) / DIV_E;
            day = b - d - (DIV_E * e) / SCALE_E;
            month = e - ((e < jdc_pkg::MONTH_SPLIT) ? jdc_pkg::MONTH_LOW_OFS
                                                    : jdc_pkg::MONTH_HIGH_OFS);
            year = c - ((month > jdc_pkg::FEB) ? jdc_pkg::YEAR_OFS_HI : jdc_pkg::YEAR_OFS_LO);

            r.year  = year[jdc_pkg::YEAR_W-1:0];
            r.month = month[jdc_pkg::MONTH_W-1:0];
            r.day   = day[jdc_pkg::DAY_W-1:0];
            r.dayf  = dayf[jdc_pkg::FRAC_BITS-1:0];
            return r;
        endfunction

        function void note_julian_date(logic [23:0] whole, logic [32:0] frac);
            pending.push_back(julian_to_date(whole, frac));
        endfunction

        function void report_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // compare one output word with the oldest expected date
        function void check_date(logic [jdc_pkg::OUT_DATA_W-1:0] word);
            jdc_pkg::date_t got, want;
            got = word[DATE_W-1:0];
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual year %0d month %0d day %0d",
                         $time, $signed(got.year), got.month, got.day);
                return;
            end
            want = pending.pop_front();
            report_field("cal_year", want.year, got.year);
            report_field("cal_month", want.month, got.month);
            report_field("cal_day", want.day, got.day);
            report_field("day_frac", want.dayf, got.dayf);
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [jdc_pkg::IN_DATA_W-1:0]      s_tdata = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [jdc_pkg::OUT_DATA_W-1:0]     m_tdata;

    date_scoreboard sb = new();
    bit idling = 1'b1;
    bit hold_req = 1'b0;

    julian_day_to_calendar dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // offer one julian date, wait until it is taken
    task automatic send_word(input longint whole, input longint frac);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{IN_PAD{1'b0}}, frac[32:0], whole[23:0]};
        do @(posedge clk); while (!s_tready);
        sb.note_julian_date(whole[23:0], frac[32:0]);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // receiver: random stall bursts and one long hold
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idling && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // output word check
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_date(m_tdata);
    end

    // watchdog: cycles with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        longint whole, frac;
        logic [32:0] frac_bits;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, half day carry and borrow, gregorian and negative edges
        send_word(0, 0);
        send_word(-1, -1);
        send_word(8388607, 64'sd4294967295);
        send_word(-8388608, -64'sd4294967296);
        send_word(-8388608, 64'sd4294967295);
        send_word(8388607, -64'sd4294967296);
        send_word(0, -64'sd4294967296);
        send_word(2299160, 64'sd2147483647);
        send_word(2299160, 64'sd2147483648);
        send_word(2299161, -64'sd2147483648);
        send_word(2299161, -64'sd2147483649);
        send_word(2299159, 0);
        send_word(-1401, 0);
        send_word(-1402, 0);
        send_word(-1402, 64'sd2147483648);
        send_word(-1400, -64'sd2147483649);
        send_word(2451545, 0);
        send_word(2451544, 64'sd4294967295);
        send_word(-1, 64'sd2147483648);
        send_word(1, -64'sd2147483649);
        send_word(8388607, 64'sd2147483648);
        send_word(-8388608, -64'sd2147483649);
        s_tvalid <= 1'b0;
        wait_drained();

        // random dates, biased toward the interesting day ranges
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 100 == 0)
                idling = ($urandom_range(0, 3) != 0);
            if (i >= RANDOM_WORDS - CALM_TAIL)
                idling = 1'b0;
            if (i == 300)
                hold_req = 1'b1;
            if (i == 650)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end

            case ($urandom_range(0, 9))
                0, 1, 2: whole = longint'($signed(24'($urandom)));
                3, 4:    whole = jdc_pkg::GREG_START + $urandom_range(0, 600000);
                5:       whole = jdc_pkg::GREG_START - 10 + $urandom_range(0, 20);
                6:       whole = jdc_pkg::NEG_FIX_LIMIT - 10 + $urandom_range(0, 20);
                7:       whole = ($urandom_range(0, 1) != 0) ? 8388607 - $urandom_range(0, 5)
                                                            : -8388608 + $urandom_range(0, 5);
                default: whole = longint'($urandom_range(0, 1600000)) - 800000;
            endcase

            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    frac_bits = {1'($urandom_range(0, 1)), 32'($urandom)};
                    frac = longint'($signed(frac_bits));
                end
                3: frac = (($urandom_range(0, 1) != 0) ? 64'sd2147483648 : -64'sd2147483648)
                          + longint'($urandom_range(0, 6)) - 3;
                4: frac = ($urandom_range(0, 1) != 0)
                          ? 64'sd4294967295 - $urandom_range(0, 3)
                          : -64'sd4294967296 + $urandom_range(0, 3);
                default: frac = longint'($urandom_range(0, 7)) - 4;
            endcase

            send_word(whole, frac);
        end
        s_tvalid <= 1'b0;

        // let the pipeline empty, then keep watching the output for stray words
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
